// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/nhlfu_pkg.sv -----
// ----------------------------------------------------------------------------
// nhlfu_pkg
// Types, constants and helpers of the N-hit admission LFU cache.
// ----------------------------------------------------------------------------
package nhlfu_pkg;

   localparam int ADDR_BITS   = 10;
   localparam int CAPACITY    = 16;
   localparam int COUNT_BITS  = 16;

   localparam int ADDR_DEPTH  = 1 << ADDR_BITS;
   localparam int IDX_BITS    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int USED_BITS   = $clog2(CAPACITY + 1);
   localparam int ORDER_BITS  = 32;
   localparam int TALLY_BITS  = 32;
   localparam int STAMP_BITS  = 48;
   localparam int PORT_ADDR_BITS = 10;
   localparam int CAPREG_BITS = 5;
   localparam int THR_BITS    = 16;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CAPACITY     = 2'd0,
      CSR_THRESHOLD    = 2'd1,
      CSR_WINDOW_START = 2'd2,
      CSR_WINDOW_END   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_WINDOW,
      S_LOOKUP,
      S_DECIDE,
      S_VICTIM,
      S_EVICT,
      S_INSERT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                  valid;
      logic [ADDR_BITS-1:0]  tag;
      logic [COUNT_BITS-1:0] count;
      logic [ORDER_BITS-1:0] order;
   } entry_type;

   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] idx;
      entry_type           entry;
   } entry_wr_type;

   typedef struct packed {
      logic match;
      logic better;
   } scan_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

// ----- hw/rtl/nhlfu_ram.sv -----
// ----------------------------------------------------------------------------
// nhlfu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nhlfu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/nhlfu_entries.sv -----
// ----------------------------------------------------------------------------
// nhlfu_entries
// Cache entry table: valid bits plus tag, count and insertion order per slot.
// ----------------------------------------------------------------------------
module nhlfu_entries
   import nhlfu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_BITS-1:0] rd_idx,
   output entry_type           rd_entry,
   input  entry_wr_type        wr
);

   logic [CAPACITY-1:0]   valid_ff;
   logic [ADDR_BITS-1:0]  tag_ff   [CAPACITY];
   logic [COUNT_BITS-1:0] count_ff [CAPACITY];
   logic [ORDER_BITS-1:0] order_ff [CAPACITY];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= wr.entry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         tag_ff[wr.idx]   <= wr.entry.tag;
         count_ff[wr.idx] <= wr.entry.count;
         order_ff[wr.idx] <= wr.entry.order;
      end
   end

   always_comb begin
      rd_entry.valid = valid_ff[rd_idx];
      rd_entry.tag   = tag_ff[rd_idx];
      rd_entry.count = count_ff[rd_idx];
      rd_entry.order = order_ff[rd_idx];
   end

endmodule

// ----- hw/rtl/nhlfu_scan.sv -----
// ----------------------------------------------------------------------------
// nhlfu_scan
// Shared compare unit: checks one entry per cycle for a tag match and for
// being a better eviction candidate than the best one found so far.
// ----------------------------------------------------------------------------
module nhlfu_scan
   import nhlfu_pkg::*;
(
   input  entry_type             cur,
   input  logic [ADDR_BITS-1:0]  addr,
   input  logic                  best_found,
   input  logic [COUNT_BITS-1:0] best_count,
   input  logic [ORDER_BITS-1:0] best_order,
   output scan_type              result
);

   logic count_lt;
   logic count_eq;
   logic order_lt;

   assign count_lt = cur.count < best_count;
   assign count_eq = cur.count == best_count;
   assign order_lt = cur.order < best_order;

   always_comb begin
      result.match  = cur.valid && (cur.tag == addr);
      // Lowest count wins, and among equal counts the earliest insertion.
      result.better = cur.valid &&
                      (!best_found || count_lt || (count_eq && order_lt));
   end

endmodule

// ----- hw/rtl/n_hit_admission_lfu_cache_top.sv -----
// ----------------------------------------------------------------------------
// n_hit_admission_lfu_cache_top
// Outside the window a word goes from accept straight to the result strobe;
// inside, a lookup scan follows; then a hit or a non-admitting miss ends,
// an admission into a free slot inserts, and one into a full table first
// scans for a victim and evicts. Busy drops the cycle after the strobe.
// Scans check one entry per cycle; after reset the block clears the address
// counter RAM, busy high. Results are strobed once; receivers cannot stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module n_hit_admission_lfu_cache_top
   import nhlfu_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_action,
   input  logic [STAMP_BITS-1:0]     req_stamp,
   input  logic [PORT_ADDR_BITS-1:0] req_block_address,
   output logic                      rsp_valid,
   output logic                      rsp_in_window,
   output logic                      rsp_hit,
   output logic                      rsp_cold_miss,
   output logic                      rsp_admitted,
   output logic                      rsp_evicted,
   output logic [PORT_ADDR_BITS-1:0] rsp_victim_address,
   output logic [TALLY_BITS-1:0]     rsp_read_hit_total,
   output logic [TALLY_BITS-1:0]     rsp_read_miss_total,
   output logic [TALLY_BITS-1:0]     rsp_write_hit_total,
   output logic [TALLY_BITS-1:0]     rsp_write_miss_total,
   output logic [TALLY_BITS-1:0]     rsp_cold_miss_total,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [STAMP_BITS-1:0]     csr_wdata
);

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CAPACITY - 1);

   state_type state_ff, state_in;

   logic [CAPREG_BITS-1:0] cfg_cap_ff;
   logic [THR_BITS-1:0]    cfg_thr_ff;
   logic [STAMP_BITS-1:0]  cfg_wstart_ff;
   logic [STAMP_BITS-1:0]  cfg_wend_ff;

   logic [ADDR_BITS-1:0]  clr_idx_ff;
   logic                  action_ff;
   logic [STAMP_BITS-1:0] stamp_ff;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic [COUNT_BITS-1:0] seen_ff;

   logic [IDX_BITS-1:0]   scan_idx_ff;
   logic [IDX_BITS-1:0]   slot_ff;
   logic [IDX_BITS-1:0]   free_ff;
   logic                  free_found_ff;
   logic [USED_BITS-1:0]  used_ff;
   logic                  best_found_ff;
   logic [IDX_BITS-1:0]   best_ff;
   logic [COUNT_BITS-1:0] best_count_ff;
   logic [ORDER_BITS-1:0] best_order_ff;
   logic [ADDR_BITS-1:0]  best_tag_ff;
   logic [ORDER_BITS-1:0] next_order_ff;

   logic                      in_window_ff;
   logic                      hit_ff;
   logic                      cold_ff;
   logic                      admitted_ff;
   logic                      evicted_ff;
   logic [PORT_ADDR_BITS-1:0] victim_ff;

   logic [TALLY_BITS-1:0] rd_hit_ff;
   logic [TALLY_BITS-1:0] rd_miss_ff;
   logic [TALLY_BITS-1:0] wr_hit_ff;
   logic [TALLY_BITS-1:0] wr_miss_ff;
   logic [TALLY_BITS-1:0] cold_total_ff;

   logic                  accept;
   logic                  in_window;
   logic [COUNT_BITS-1:0] seen_new;
   logic                  admit_ok;
   logic [8:0]            cap_eff;
   logic                  full;
   logic                  last_idx;

   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic [COUNT_BITS-1:0] ram_wr_data;
   logic [COUNT_BITS-1:0] ram_rd_data;

   logic [IDX_BITS-1:0] ent_rd_idx;
   entry_type           ent_rd;
   entry_wr_type        ent_wr;
   scan_type            scan;

   nhlfu_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (ADDR_DEPTH)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (ADDR_BITS'(req_block_address)),
      .rd_data (ram_rd_data)
   );

   nhlfu_entries u_entries (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (ent_rd_idx),
      .rd_entry (ent_rd),
      .wr       (ent_wr)
   );

   nhlfu_scan u_scan (
      .cur        (ent_rd),
      .addr       (addr_ff),
      .best_found (best_found_ff),
      .best_count (best_count_ff),
      .best_order (best_order_ff),
      .result     (scan)
   );

   assign accept    = start && (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign in_window = (stamp_ff >= cfg_wstart_ff) && (stamp_ff <= cfg_wend_ff);
   assign seen_new  = sat_inc(seen_ff);
   assign admit_ok  = 32'(seen_new) >= 32'(cfg_thr_ff);
   assign last_idx  = scan_idx_ff == LAST_IDX;

   // A capacity of zero acts as one, and anything above the table size as full size.
   always_comb begin
      cap_eff = 9'(cfg_cap_ff);
      if (cap_eff == 9'd0) begin
         cap_eff = 9'd1;
      end else if (cap_eff > 9'(CAPACITY)) begin
         cap_eff = 9'(CAPACITY);
      end
   end

   assign full = 9'(used_ff) >= cap_eff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_idx_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_WINDOW;
            end
         end
         S_WINDOW: begin
            state_in = in_window ? S_LOOKUP : S_DONE;
         end
         S_LOOKUP: begin
            if (last_idx) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (hit_ff || !admit_ok) begin
               state_in = S_DONE;
            end else if (full) begin
               state_in = S_VICTIM;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_VICTIM: begin
            if (last_idx) begin
               state_in = S_EVICT;
            end
         end
         S_EVICT:  state_in = S_INSERT;
         S_INSERT: state_in = S_DONE;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = seen_new;
      ent_rd_idx  = scan_idx_ff;
      ent_wr      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_ff;
            ram_wr_data = '0;
         end
         S_IDLE: begin
            busy = 1'b0;
         end
         S_DECIDE: begin
            ram_wr_en  = 1'b1;
            ent_rd_idx = slot_ff;
            if (hit_ff) begin
               ent_wr.en          = 1'b1;
               ent_wr.idx         = slot_ff;
               ent_wr.entry       = ent_rd;
               ent_wr.entry.valid = 1'b1;
               ent_wr.entry.count = sat_inc(ent_rd.count);
            end
         end
         S_EVICT: begin
            if (best_found_ff) begin
               ent_wr.en          = 1'b1;
               ent_wr.idx         = best_ff;
               ent_wr.entry.valid = 1'b0;
               ent_wr.entry.tag   = best_tag_ff;
               ent_wr.entry.count = best_count_ff;
               ent_wr.entry.order = best_order_ff;
            end
         end
         S_INSERT: begin
            if (free_found_ff) begin
               ent_wr.en          = 1'b1;
               ent_wr.idx         = free_ff;
               ent_wr.entry.valid = 1'b1;
               ent_wr.entry.tag   = addr_ff;
               ent_wr.entry.count = seen_ff;
               ent_wr.entry.order = next_order_ff;
            end
         end
         S_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_idx_ff    <= '0;
         cfg_cap_ff    <= CAPREG_BITS'(16);
         cfg_thr_ff    <= THR_BITS'(2);
         cfg_wstart_ff <= '0;
         cfg_wend_ff   <= '1;
         next_order_ff <= '0;
         rd_hit_ff     <= '0;
         rd_miss_ff    <= '0;
         wr_hit_ff     <= '0;
         wr_miss_ff    <= '0;
         cold_total_ff <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_CAPACITY:     cfg_cap_ff    <= csr_wdata[CAPREG_BITS-1:0];
               CSR_THRESHOLD:    cfg_thr_ff    <= csr_wdata[THR_BITS-1:0];
               CSR_WINDOW_START: cfg_wstart_ff <= csr_wdata;
               CSR_WINDOW_END:   cfg_wend_ff   <= csr_wdata;
               default:          cfg_cap_ff    <= cfg_cap_ff;
            endcase
         end

         if (state_ff == S_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end

         if (state_ff == S_DECIDE) begin
            if (hit_ff) begin
               if (action_ff) begin
                  if (wr_hit_ff != '1) wr_hit_ff <= wr_hit_ff + 1'b1;
               end else begin
                  if (rd_hit_ff != '1) rd_hit_ff <= rd_hit_ff + 1'b1;
               end
            end else begin
               if (action_ff) begin
                  if (wr_miss_ff != '1) wr_miss_ff <= wr_miss_ff + 1'b1;
               end else begin
                  if (rd_miss_ff != '1) rd_miss_ff <= rd_miss_ff + 1'b1;
               end
               if (seen_ff == '0 && cold_total_ff != '1) begin
                  cold_total_ff <= cold_total_ff + 1'b1;
               end
            end
         end

         if (state_ff == S_INSERT && free_found_ff && next_order_ff != '1) begin
            next_order_ff <= next_order_ff + 1'b1;
         end
      end
   end

   // Datapath registers of the word in flight.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               action_ff    <= req_action;
               stamp_ff     <= req_stamp;
               addr_ff      <= ADDR_BITS'(req_block_address);
               in_window_ff <= 1'b0;
               hit_ff       <= 1'b0;
               cold_ff      <= 1'b0;
               admitted_ff  <= 1'b0;
               evicted_ff   <= 1'b0;
               victim_ff    <= '0;
            end
         end
         S_WINDOW: begin
            seen_ff       <= ram_rd_data;
            in_window_ff  <= in_window;
            scan_idx_ff   <= '0;
            free_found_ff <= 1'b0;
            used_ff       <= '0;
         end
         S_LOOKUP: begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
            if (scan.match) begin
               hit_ff  <= 1'b1;
               slot_ff <= scan_idx_ff;
            end
            if (ent_rd.valid) begin
               used_ff <= used_ff + 1'b1;
            end else if (!free_found_ff) begin
               free_found_ff <= 1'b1;
               free_ff       <= scan_idx_ff;
            end
         end
         S_DECIDE: begin
            seen_ff       <= seen_new;
            cold_ff       <= !hit_ff && (seen_ff == '0);
            scan_idx_ff   <= '0;
            best_found_ff <= 1'b0;
         end
         S_VICTIM: begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
            if (scan.better) begin
               best_found_ff <= 1'b1;
               best_ff       <= scan_idx_ff;
               best_count_ff <= ent_rd.count;
               best_order_ff <= ent_rd.order;
               best_tag_ff   <= ent_rd.tag;
            end
         end
         S_EVICT: begin
            if (best_found_ff) begin
               evicted_ff <= 1'b1;
               victim_ff  <= PORT_ADDR_BITS'(best_tag_ff);
               // The freed slot is used unless a lower slot was already empty.
               if (!free_found_ff || best_ff < free_ff) begin
                  free_found_ff <= 1'b1;
                  free_ff       <= best_ff;
               end
            end
         end
         S_INSERT: begin
            if (free_found_ff) begin
               admitted_ff <= 1'b1;
            end
         end
         default: begin
            scan_idx_ff <= scan_idx_ff;
         end
      endcase
   end

   assign rsp_in_window        = in_window_ff;
   assign rsp_hit              = hit_ff;
   assign rsp_cold_miss        = cold_ff;
   assign rsp_admitted         = admitted_ff;
   assign rsp_evicted          = evicted_ff;
   assign rsp_victim_address   = victim_ff;
   assign rsp_read_hit_total   = rd_hit_ff;
   assign rsp_read_miss_total  = rd_miss_ff;
   assign rsp_write_hit_total  = wr_hit_ff;
   assign rsp_write_miss_total = wr_miss_ff;
   assign rsp_cold_miss_total  = cold_total_ff;

   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_SAME(a_outside_quiet, clock, reset, rsp_valid && !rsp_in_window, !rsp_hit && !rsp_cold_miss && !rsp_admitted && !rsp_evicted && (rsp_victim_address == '0))
   `ASSERT_SAME(a_hit_no_insert, clock, reset, rsp_valid && rsp_hit, !rsp_admitted && !rsp_evicted && !rsp_cold_miss)
   `ASSERT_SAME(a_evict_admits, clock, reset, rsp_valid && rsp_evicted, rsp_admitted)

endmodule
